// ----- rtl/core/postfix_expression_evaluator_defines.svh -----
// Assertion macros shared by the evaluator RTL.
`ifndef POSTFIX_EXPRESSION_EVALUATOR_DEFINES_SVH
`define POSTFIX_EXPRESSION_EVALUATOR_DEFINES_SVH
// Assert that an antecedent implies a consequent in the same cycle.
`define PEE_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// Assert that an antecedent implies a consequent in the next cycle.
`define PEE_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`endif

// ----- rtl/core/pee_pkg.sv -----
// Package with types, constants and commands of the postfix evaluator.
package pee_pkg;
   localparam int unsigned StackDepth = 128;
   localparam int unsigned PtrW = $clog2(StackDepth);
   localparam int unsigned CntW = $clog2(StackDepth + 1);
   localparam int unsigned DataW = 32;

   localparam logic [7:0] ChZero = 8'h30;
   localparam logic [7:0] ChNine = 8'h39;
   localparam logic [7:0] ChAdd = 8'h2B;
   localparam logic [7:0] ChSub = 8'h2D;
   localparam logic [7:0] ChMul = 8'h2A;
   localparam logic [7:0] ChDiv = 8'h2F;
   localparam logic [7:0] ChPow = 8'h5E;

   typedef enum logic [2:0] {
      OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_POW
   } op_type;

   // Controller to datapath commands.
   typedef struct packed {
      logic       start;      // launch arithmetic on lhs/rhs
      op_type     op;
      logic       load_rhs;   // capture read data (or -1) as rhs
      logic       load_lhs;
      logic       pop_empty;  // popped operand is -1
   } cmd_type;

   // Datapath to controller status.
   typedef struct packed {
      logic             done;
      logic             div_zero;
      logic [DataW-1:0] result;
   } stat_type;
endpackage

// ----- rtl/core/pee_ram.sv -----
// Generic single-port-write, registered-read RAM.
module pee_ram #(
   parameter int unsigned Width = 32,
   parameter int unsigned Depth = 128
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] wr_addr,
   input  logic [Width-1:0]         wr_data,
   input  logic [$clog2(Depth)-1:0] rd_addr,
   output logic [Width-1:0]         rd_data
);
   logic [Width-1:0] mem_ff [Depth];
   logic [Width-1:0] rd_data_ff;

   // Write and registered read.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end
   assign rd_data = rd_data_ff;
endmodule

// ----- rtl/core/pee_datapath.sv -----
// Operand registers and iterative arithmetic unit.
module pee_datapath (
   input  logic                 clock,
   input  logic                 reset,
   input  pee_pkg::cmd_type     cmd,
   input  logic [31:0]          rd_data,
   output pee_pkg::stat_type    stat
);
   import pee_pkg::*;

   typedef enum logic [1:0] {ST_IDLE, ST_DIV, ST_POW, ST_DONE} dstate_type;

   dstate_type  state_ff;
   logic [31:0] lhs_ff, rhs_ff, res_ff;
   logic [31:0] quo_ff, rem_ff, dvs_ff;
   logic [5:0]  cnt_ff;
   logic        qneg_ff, dz_ff;
   logic [31:0] mag_ff, exp_ff;
   logic [32:0] acc_ff;
   logic        pneg_ff;
   logic [32:0] limit_ff;
   logic [31:0] pop_val;
   logic [31:0] a_abs, b_abs;
   logic [32:0] rem_sh;
   logic [32:0] rem_sub;
   logic [65:0] prod;
   logic [31:0] mul_lo;

   assign pop_val = cmd.pop_empty ? 32'hFFFF_FFFF : rd_data;
   assign a_abs = lhs_ff[31] ? (32'd0 - lhs_ff) : lhs_ff;
   assign b_abs = rhs_ff[31] ? (32'd0 - rhs_ff) : rhs_ff;
   assign rem_sh = {rem_ff, quo_ff[31]};
   assign rem_sub = rem_sh - {1'b0, dvs_ff};
   assign prod = acc_ff * {1'b0, mag_ff};
   assign mul_lo = lhs_ff * rhs_ff;

   // Sequence the arithmetic; one quotient bit or one power factor per cycle.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         dz_ff <= 1'b0;
      end else begin
         if (cmd.load_rhs) rhs_ff <= pop_val;
         if (cmd.load_lhs) lhs_ff <= pop_val;
         unique case (state_ff)
            ST_IDLE: begin
               dz_ff <= cmd.start && (cmd.op == OP_DIV) && (rhs_ff == 32'd0);
               if (cmd.start) begin
                  unique case (cmd.op)
                     OP_ADD: begin res_ff <= lhs_ff + rhs_ff; state_ff <= ST_DONE; end
                     OP_SUB: begin res_ff <= lhs_ff - rhs_ff; state_ff <= ST_DONE; end
                     OP_MUL: begin res_ff <= mul_lo; state_ff <= ST_DONE; end
                     OP_DIV: begin
                        if (rhs_ff == 32'd0) begin
                           res_ff <= 32'd0;
                           state_ff <= ST_DONE;
                        end else begin
                           quo_ff <= a_abs;
                           rem_ff <= 32'd0;
                           dvs_ff <= b_abs;
                           qneg_ff <= lhs_ff[31] ^ rhs_ff[31];
                           cnt_ff <= 6'd32;
                           state_ff <= ST_DIV;
                        end
                     end
                     default: begin
                        // Power: resolve trivial cases, else iterate.
                        if (rhs_ff == 32'd0) begin
                           res_ff <= 32'd1; state_ff <= ST_DONE;
                        end else if (rhs_ff[31]) begin
                           if (lhs_ff == 32'd1) res_ff <= 32'd1;
                           else if (lhs_ff == 32'hFFFF_FFFF)
                              res_ff <= rhs_ff[0] ? 32'hFFFF_FFFF : 32'd1;
                           else if (lhs_ff == 32'd0) res_ff <= 32'h7FFF_FFFF;
                           else res_ff <= 32'd0;
                           state_ff <= ST_DONE;
                        end else if (a_abs <= 32'd1) begin
                           res_ff <= (lhs_ff[31] && rhs_ff[0]) ? 32'hFFFF_FFFF : a_abs;
                           state_ff <= ST_DONE;
                        end else begin
                           pneg_ff <= lhs_ff[31] & rhs_ff[0];
                           limit_ff <= (lhs_ff[31] & rhs_ff[0]) ? 33'h0_8000_0000
                                                               : 33'h0_7FFF_FFFF;
                           mag_ff <= a_abs;
                           exp_ff <= rhs_ff;
                           acc_ff <= 33'd1;
                           state_ff <= ST_POW;
                        end
                     end
                  endcase
               end
            end
            ST_DIV: begin
               // Restoring division, one bit per cycle, then apply the sign.
               if (cnt_ff == 6'd0) begin
                  res_ff <= qneg_ff ? (32'd0 - quo_ff) : quo_ff;
                  state_ff <= ST_DONE;
               end else begin
                  if (!rem_sub[32]) begin
                     rem_ff <= rem_sub[31:0];
                     quo_ff <= {quo_ff[30:0], 1'b1};
                  end else begin
                     rem_ff <= rem_sh[31:0];
                     quo_ff <= {quo_ff[30:0], 1'b0};
                  end
                  cnt_ff <= cnt_ff - 6'd1;
               end
            end
            ST_POW: begin
               // Multiply once per cycle; stop at saturation or on the last factor.
               if (prod > {33'd0, limit_ff}) begin
                  res_ff <= pneg_ff ? 32'h8000_0000 : 32'h7FFF_FFFF;
                  state_ff <= ST_DONE;
               end else if (exp_ff == 32'd1) begin
                  res_ff <= pneg_ff ? (32'd0 - prod[31:0]) : prod[31:0];
                  state_ff <= ST_DONE;
               end else begin
                  acc_ff <= prod[32:0];
                  exp_ff <= exp_ff - 32'd1;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign stat.done = (state_ff == ST_DONE);
   assign stat.div_zero = dz_ff;
   assign stat.result = res_ff;
endmodule

// ----- rtl/core/pee_control.sv -----
// Controller: decodes characters, drives the stack and the output register.
module pee_control (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [7:0]            req_tdata,
   input  logic                  req_tlast,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [39:0]           rsp_tdata,
   output pee_pkg::cmd_type      cmd,
   input  pee_pkg::stat_type     stat,
   output logic                  wr_en,
   output logic [pee_pkg::PtrW-1:0] wr_addr,
   output logic [31:0]           wr_data,
   output logic [pee_pkg::PtrW-1:0] rd_addr,
   input  logic [31:0]           rd_data
);
   import pee_pkg::*;

   typedef enum logic [2:0] {
      S_IDLE, S_POP1, S_POP2, S_POP2W, S_EXEC, S_WAIT, S_FIN, S_FINR
   } state_type;

   state_type         state_ff;
   logic [CntW-1:0]   count_ff;
   logic              unf_ff, ovf_ff, dz_ff, last_ff;
   op_type            op_ff;
   logic              empty1_ff;
   logic              rsp_valid_ff;
   logic [39:0]       rsp_data_ff;
   logic              is_digit, is_op;
   op_type            dec_op;
   logic              full;
   logic [CntW-1:0]   count_m1;
   logic [31:0]       top_val;
   logic              rsp_load;

   assign is_digit = (req_tdata >= ChZero) && (req_tdata <= ChNine);
   assign full = (count_ff == CntW'(StackDepth));
   assign count_m1 = count_ff - CntW'(1);

   // Decode operator characters.
   always_comb begin
      is_op = 1'b1;
      dec_op = OP_ADD;
      unique case (req_tdata)
         ChAdd: dec_op = OP_ADD;
         ChSub: dec_op = OP_SUB;
         ChMul: dec_op = OP_MUL;
         ChDiv: dec_op = OP_DIV;
         ChPow: dec_op = OP_POW;
         default: is_op = 1'b0;
      endcase
   end

   assign req_tready = (state_ff == S_IDLE) && !(req_tlast && rsp_valid_ff);

   // Drive stack reads and pushes.
   always_comb begin
      rd_addr = count_m1[PtrW-1:0];
      wr_en = 1'b0;
      wr_addr = count_ff[PtrW-1:0];
      wr_data = stat.result;
      cmd = '0;
      cmd.op = op_ff;
      if (state_ff == S_IDLE && req_tvalid && req_tready && is_digit && !full) begin
         wr_en = 1'b1;
         wr_data = {24'd0, req_tdata - ChZero};
      end
      if (state_ff == S_POP1) begin
         cmd.load_rhs = 1'b1;
         cmd.pop_empty = empty1_ff;
      end
      if (state_ff == S_POP2) begin
         cmd.load_lhs = 1'b1;
         cmd.pop_empty = empty1_ff;
      end
      if (state_ff == S_EXEC) cmd.start = 1'b1;
      if (state_ff == S_WAIT && stat.done) wr_en = 1'b1;
   end

   assign top_val = (count_ff == '0) ? 32'hFFFF_FFFF : rd_data;
   assign rsp_load = (state_ff == S_FINR) && (!rsp_valid_ff || rsp_tready);

   // Hold state, counters, flags and the output register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
         unf_ff <= 1'b0;
         ovf_ff <= 1'b0;
         dz_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         last_ff <= 1'b0;
         empty1_ff <= 1'b0;
         op_ff <= OP_ADD;
      end else begin
         if (rsp_load) rsp_valid_ff <= 1'b1;
         else if (rsp_valid_ff && rsp_tready) rsp_valid_ff <= 1'b0;
         unique case (state_ff)
            S_IDLE: begin
               if (req_tvalid && req_tready) begin
                  last_ff <= req_tlast;
                  if (is_digit) begin
                     if (full) ovf_ff <= 1'b1;
                     else count_ff <= count_ff + CntW'(1);
                     state_ff <= req_tlast ? S_FIN : S_IDLE;
                  end else if (is_op) begin
                     op_ff <= dec_op;
                     empty1_ff <= (count_ff == '0);
                     if (count_ff == '0) unf_ff <= 1'b1;
                     else count_ff <= count_m1;
                     state_ff <= S_POP1;
                  end else begin
                     state_ff <= req_tlast ? S_FIN : S_IDLE;
                  end
               end
            end
            S_POP1: begin
               empty1_ff <= (count_ff == '0);
               if (count_ff == '0) unf_ff <= 1'b1;
               else count_ff <= count_m1;
               state_ff <= S_POP2;
            end
            S_POP2: state_ff <= S_POP2W;
            S_POP2W: state_ff <= S_EXEC;
            S_EXEC: state_ff <= S_WAIT;
            S_WAIT: begin
               if (stat.done) begin
                  count_ff <= count_ff + CntW'(1);
                  if (stat.div_zero) dz_ff <= 1'b1;
                  state_ff <= last_ff ? S_FIN : S_IDLE;
               end
            end
            S_FIN: state_ff <= S_FINR;
            S_FINR: begin
               if (rsp_load) begin
                  rsp_data_ff <= {4'd0, dz_ff, ovf_ff, unf_ff, (count_ff == '0), top_val};
                  count_ff <= '0;
                  unf_ff <= 1'b0;
                  ovf_ff <= 1'b0;
                  dz_ff <= 1'b0;
                  state_ff <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata = rsp_data_ff;
endmodule

// ----- rtl/core/postfix_expression_evaluator.sv -----
// Top level of the postfix expression evaluator.
// Usage:
//   req_*: one ASCII character per request in req_tdata, req_tlast on the
//   final character. Digits push, + - * / ^ pop two and push the result,
//   anything else is ignored.
//   rsp_*: one result per expression, after the request with req_tlast:
//   top of stack (or -1) and the sticky underflow/overflow/divide flags.
// Sequencing:
//   A digit or ignored character is taken directly in the idle state. An
//   operator passes through the pop, execute and wait states; / takes one
//   quotient bit per cycle in the divider and ^ one multiply per cycle. The
//   final character then reads the stack top into the output register.
// Reset clears the stack count, the flags and the output valid; the
// operand memory needs no clearing.
// A stalled receiver holds the result; new characters are still taken
// until another final character arrives while the result waits.
module postfix_expression_evaluator (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // character[7:0]
   input  logic        req_tlast,   // last
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata    // value[31:0], stack_empty, underflow_seen,
                                    // overflow_seen, divide_by_zero, zero pad
);
   import pee_pkg::*;
   `include "postfix_expression_evaluator_defines.svh"

   cmd_type          cmd;
   stat_type         stat;
   logic             wr_en;
   logic [PtrW-1:0]  wr_addr, rd_addr;
   logic [31:0]      wr_data, rd_data;

   pee_control u_control (
      .clock, .reset, .req_tvalid, .req_tready, .req_tdata, .req_tlast,
      .rsp_tvalid, .rsp_tready, .rsp_tdata, .cmd, .stat,
      .wr_en, .wr_addr, .wr_data, .rd_addr, .rd_data
   );

   pee_datapath u_datapath (
      .clock, .reset, .cmd, .rd_data, .stat
   );

   pee_ram #(.Width(DataW), .Depth(StackDepth)) u_stack (
      .clock, .wr_en, .wr_addr, .wr_data, .rd_addr, .rd_data
   );

   // A result waiting and unaccepted must stay unchanged.
   `PEE_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, $stable(rsp_tdata), "rsp changed while stalled")
   // Stack empty flag must match a value of -1.
   `PEE_ASSERT_IMP(a_empty_val, clock, reset, rsp_tvalid && rsp_tdata[32], rsp_tdata[31:0] == 32'hFFFF_FFFF, "empty result not -1")
   // Pad bits stay zero.
   `PEE_ASSERT_IMP(a_pad, clock, reset, rsp_tvalid, rsp_tdata[39:36] == 4'd0, "pad bits set")
endmodule
